// ----- hw/rtl/assert_macros.svh -----
// assertion helpers for the rtl files
// expects clk and rst in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante implies cons at the same clock edge
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// cond never holds at a clock edge
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

// ----- hw/rtl/cda_pkg.sv -----
// types and constants for the 2d correlation accumulate block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cda_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 40;
  localparam int POS_W    = 7;
  // sum headroom for up to 32x32 taps of q8.8 by q8.8 on top of a 40 bit seed
  localparam int ACC_W    = 48;

  typedef enum logic [1:0] {
    OP_KERNEL = 2'd0,
    OP_IMAGE  = 2'd1,
    OP_CONV   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_ROWS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_COLS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_MODE   = 3'd4;

  // register reset values
  localparam logic [6:0] RST_IMAGE_ROWS  = 7'd64;
  localparam logic [6:0] RST_IMAGE_COLS  = 7'd64;
  localparam logic [3:0] RST_KERNEL_ROWS = 4'd3;
  localparam logic [3:0] RST_KERNEL_COLS = 4'd3;

  localparam logic signed [ACC_W-1:0] ACC_SUM_MAX =
    {{(ACC_W-SUM_W+1){1'b0}}, {(SUM_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_SUM_MIN =
    {{(ACC_W-SUM_W+1){1'b1}}, {(SUM_W-1){1'b0}}};

  typedef struct packed {
    op_t                        op;
    logic [POS_W-1:0]           row;
    logic [POS_W-1:0]           col;
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [SUM_W-1:0]    seed;
  } in_word_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic                    saturated;
    logic                    bad_position;
  } out_word_t;

endpackage

`default_nettype wire

// ----- hw/rtl/correlation_2d_accumulate.sv -----
// 2d cross-correlation with accumulate: one shared multiply-accumulate walks the kernel taps
// weight and pixel writes are taken back to back while idle, with no result word
// compute query: check, run over the kernel taps in image, drain, finish; no taps skips to finish
// next word taken only once idle again, as the result word appears; a held result stalls finish
// rst (synchronous) clears the sequencer, output valid and the config registers to defaults
// store contents are not cleared and must be written before they are read
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module correlation_2d_accumulate #(
  parameter int MAX_IMAGE_ROWS  = 64,
  parameter int MAX_IMAGE_COLS  = 64,
  parameter int MAX_KERNEL_ROWS = 8,
  parameter int MAX_KERNEL_COLS = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire cda_pkg::in_word_t                   in_word,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output cda_pkg::out_word_t                       out_word,
  input  wire logic                                cfg_we,
  input  wire logic [cda_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [cda_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import cda_pkg::*;

  localparam int DIM_W = $clog2(MAX_IMAGE_ROWS + MAX_IMAGE_COLS + MAX_KERNEL_ROWS
                                + MAX_KERNEL_COLS + 256) + 2;
  localparam int IR_W = (MAX_IMAGE_ROWS > 1) ? $clog2(MAX_IMAGE_ROWS) : 1;
  localparam int IC_W = (MAX_IMAGE_COLS > 1) ? $clog2(MAX_IMAGE_COLS) : 1;
  localparam int KR_W = (MAX_KERNEL_ROWS > 1) ? $clog2(MAX_KERNEL_ROWS) : 1;
  localparam int KC_W = (MAX_KERNEL_COLS > 1) ? $clog2(MAX_KERNEL_COLS) : 1;
  localparam logic [DIM_W-1:0] ONE = DIM_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RUN,
    ST_DRAIN,
    ST_FIN
  } state_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = ONE;
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // configuration
  logic [6:0] image_rows;
  logic [6:0] image_cols;
  logic [3:0] kernel_rows;
  logic [3:0] kernel_cols;
  logic       full_mode;

  // sequencer and datapath
  state_t                     state;
  logic [POS_W-1:0]           row_q;
  logic [POS_W-1:0]           col_q;
  logic signed [SUM_W-1:0]    seed_q;
  logic                       bad_q;
  logic [KR_W-1:0]            ti;
  logic [KC_W-1:0]            tj;
  logic signed [SAMPLE_W-1:0] img_q;
  logic signed [SAMPLE_W-1:0] ker_q;
  logic signed [2*SAMPLE_W-1:0] prod;
  logic                       tap_v1;
  logic                       tap_v2;
  logic signed [ACC_W-1:0]    acc;

  // stores
  logic signed [SAMPLE_W-1:0] image_mem [MAX_IMAGE_ROWS][MAX_IMAGE_COLS];
  logic signed [SAMPLE_W-1:0] kernel_mem [MAX_KERNEL_ROWS][MAX_KERNEL_COLS];

  logic                    in_fire;
  logic [DIM_W-1:0]        h, w, kh, kw;
  logic signed [DIM_W-1:0] oh, ow;
  logic [DIM_W-1:0]        wr_row, wr_col;
  logic [DIM_W-1:0]        r_w, c_w, ri_w, cj_w;
  logic                    img_wr_ok, ker_wr_ok;
  logic                    pos_bad, pos_inside;
  logic                    j_more, i_more;
  logic                    sat_hi, sat_lo;

  assign in_stall = (state != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    h  = clamp_dim(DIM_W'(image_rows), DIM_W'(MAX_IMAGE_ROWS));
    w  = clamp_dim(DIM_W'(image_cols), DIM_W'(MAX_IMAGE_COLS));
    kh = clamp_dim(DIM_W'(kernel_rows), DIM_W'(MAX_KERNEL_ROWS));
    kw = clamp_dim(DIM_W'(kernel_cols), DIM_W'(MAX_KERNEL_COLS));
    if (full_mode) begin
      oh = signed'(h + kh - ONE);
      ow = signed'(w + kw - ONE);
    end else begin
      oh = signed'(h - kh + ONE);
      ow = signed'(w - kw + ONE);
    end
  end

  always_comb begin
    wr_row    = DIM_W'(in_word.row);
    wr_col    = DIM_W'(in_word.col);
    img_wr_ok = (wr_row < DIM_W'(MAX_IMAGE_ROWS)) && (wr_col < DIM_W'(MAX_IMAGE_COLS));
    ker_wr_ok = (wr_row < DIM_W'(MAX_KERNEL_ROWS)) && (wr_col < DIM_W'(MAX_KERNEL_COLS));
  end

  always_comb begin
    r_w        = DIM_W'(row_q);
    c_w        = DIM_W'(col_q);
    pos_bad    = (signed'(r_w) >= oh) || (signed'(c_w) >= ow);
    // full mode positions past the image edge have no taps at all
    pos_inside = (r_w < h) && (c_w < w);
    ri_w       = r_w + DIM_W'(ti);
    cj_w       = c_w + DIM_W'(tj);
    j_more     = ((DIM_W'(tj) + ONE) < kw) && ((cj_w + ONE) < w);
    i_more     = ((DIM_W'(ti) + ONE) < kh) && ((ri_w + ONE) < h);
    sat_hi     = (acc > ACC_SUM_MAX);
    sat_lo     = (acc < ACC_SUM_MIN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows  <= RST_IMAGE_ROWS;
      image_cols  <= RST_IMAGE_COLS;
      kernel_rows <= RST_KERNEL_ROWS;
      kernel_cols <= RST_KERNEL_COLS;
      full_mode   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_ROWS:  image_rows  <= cfg_data[6:0];
        CFG_IMAGE_COLS:  image_cols  <= cfg_data[6:0];
        CFG_KERNEL_ROWS: kernel_rows <= cfg_data[3:0];
        CFG_KERNEL_COLS: kernel_cols <= cfg_data[3:0];
        CFG_FULL_MODE:   full_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_word.op == OP_IMAGE && img_wr_ok) begin
      image_mem[wr_row[IR_W-1:0]][wr_col[IC_W-1:0]] <= in_word.sample;
    end
    if (state == ST_RUN) begin
      img_q <= image_mem[ri_w[IR_W-1:0]][cj_w[IC_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_word.op == OP_KERNEL && ker_wr_ok) begin
      kernel_mem[wr_row[KR_W-1:0]][wr_col[KC_W-1:0]] <= in_word.sample;
    end
    if (state == ST_RUN) begin
      ker_q <= kernel_mem[ti][tj];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      tap_v1    <= 1'b0;
      tap_v2    <= 1'b0;
    end else begin
      // read -> multiply -> accumulate
      prod   <= img_q * ker_q;
      tap_v2 <= tap_v1;
      if (tap_v2) begin
        acc <= acc + ACC_W'(prod);
      end
      // the finish state loads the next word over a taken one itself
      if (out_valid && !out_stall && state != ST_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire && in_word.op == OP_CONV) begin
            row_q  <= in_word.row;
            col_q  <= in_word.col;
            seed_q <= in_word.seed;
            state  <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          acc   <= ACC_W'(seed_q);
          bad_q <= pos_bad;
          ti    <= '0;
          tj    <= '0;
          if (!pos_bad && pos_inside) begin
            state <= ST_RUN;
          end else begin
            state <= ST_FIN;
          end
        end
        ST_RUN: begin
          tap_v1 <= 1'b1;
          if (j_more) begin
            tj <= tj + KC_W'(1);
          end else if (i_more) begin
            ti <= ti + KR_W'(1);
            tj <= '0;
          end else begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          tap_v1 <= 1'b0;
          if (!tap_v1 && !tap_v2) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid             <= 1'b1;
            out_word.bad_position <= bad_q;
            out_word.saturated    <= sat_hi || sat_lo;
            if (sat_hi) begin
              out_word.sum <= ACC_SUM_MAX[SUM_W-1:0];
            end else if (sat_lo) begin
              out_word.sum <= ACC_SUM_MIN[SUM_W-1:0];
            end else begin
              out_word.sum <= acc[SUM_W-1:0];
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_IMPLY(a_bad_not_sat, out_valid && out_word.bad_position, !out_word.saturated, "bad position word flagged saturated")
  `ASSERT_IMPLY(a_taps_in_run, tap_v1 || tap_v2, state == ST_RUN || state == ST_DRAIN, "tap in flight outside run or drain")
  `ASSERT_IMPLY(a_out_from_fin, $rose(out_valid), $past(state) == ST_FIN, "result word raised outside finish")
  `ASSERT_NEVER(a_run_when_bad, state == ST_RUN && bad_q, "taps issued for a bad position")

endmodule

`default_nettype wire
